>>> hdl/wmb_pkg.sv
// ----------------------------------------------------------------------------
// wmb_pkg: shared constants of the min/max waveform binner
// Register widths, reset values and register indexes of the configuration
// port, used by the top level and its checker.
// ----------------------------------------------------------------------------
package wmb_pkg;

	// Configuration port shape.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;

	// Register widths.
	localparam int TB_W = 13;
	localparam int TS_W = 40;
	localparam int SF_W = 12;
	localparam int SE_W = 13;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_BINS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_LEN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_FIRST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_END      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_ENABLE = 3'd5;

	// Register reset values.
	localparam logic [TB_W-1:0] TRACK_BINS_RST  = 13'd4096;
	localparam logic [TS_W-1:0] TRACK_LEN_RST   = 40'd1;
	localparam logic [SF_W-1:0] SLICE_FIRST_RST = 12'd0;
	localparam logic [SE_W-1:0] SLICE_END_RST   = 13'd4096;
	localparam logic            PUBLISH_RST     = 1'b1;

endpackage

>>> hdl/waveform_minmax_binner.sv
// ----------------------------------------------------------------------------
// waveform_minmax_binner: min/max envelope decimation of a mono sample stream
// Maps each sample's track position to a bin and keeps the bin's minimum and
// maximum, plus a monotone high-water mark of the bins reached.
// ----------------------------------------------------------------------------
// Each accepted sample word takes the running position, forms position times
// the bin count in one multiply, and divides by the track length in a
// bit-serial divider that yields one quotient bit per clock. When the bin
// count or the track length is zero a word skips the divider, and a word whose
// bin misses the slice skips the memory update. The block takes no new word
// until the previous word's result is loaded into the output register; a
// result that is ready while the previous one is still stalled waits until
// that one is taken. The result sits in an output register, so a new word is
// taken while the previous result still waits. After reset the block runs a
// clearing pass over the bin memory, during which it stalls the sample
// channel; configuration writes are taken throughout.
// Configuration should be written only while the block is idle.
module waveform_minmax_binner #(
	parameter int BIN_COUNT     = 4096,
	parameter int SAMPLE_BITS   = 16,
	parameter int POSITION_BITS = 40,
	localparam int LBW = $clog2(BIN_COUNT)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Sample channel.
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic signed [SAMPLE_BITS-1:0]     sample,
	// Result channel.
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              in_slice,
	output logic [LBW-1:0]                    local_bin,
	output logic signed [SAMPLE_BITS-1:0]     bin_low,
	output logic signed [SAMPLE_BITS-1:0]     bin_high,
	output logic [LBW-1:0]                    sealed_count,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wmb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wmb_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import wmb_pkg::*;

	localparam int PB    = POSITION_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int PW    = POSITION_BITS + TB_W;
	localparam int RAM_W = 2 * SAMPLE_BITS + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_CHECK,
		ST_READ,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Configuration registers and the position counter.
	logic [TB_W-1:0] tb_q;
	logic [TS_W-1:0] ts_q;
	logic [SF_W-1:0] first_q;
	logic [SE_W-1:0] end_q;
	logic            pe_q;
	logic [PB-1:0]   pos_q;

	// Per-word working registers.
	logic signed [SB-1:0] sample_q;
	logic [PW-1:0]        prod_q;
	logic [LBW-1:0]       local_q;
	logic [LBW-1:0]       hw_q;
	logic [LBW-1:0]       clr_q;
	logic                 res_in_q;
	logic signed [SB-1:0] res_lo_q;
	logic signed [SB-1:0] res_hi_q;

	// Output register.
	logic                 result_valid_q;
	logic                 in_slice_q;
	logic [LBW-1:0]       local_bin_q;
	logic signed [SB-1:0] bin_low_q;
	logic signed [SB-1:0] bin_high_q;
	logic [LBW-1:0]       sealed_q;

	logic                 item_accept;
	logic                 no_bin;
	logic                 div_start;
	logic                 div_done;
	logic [PW-1:0]        quo;
	logic                 bin_ge;
	logic                 bin_lt;
	logic [PW-1:0]        bin_off;
	logic                 bin_fits;

	logic                 ram_we;
	logic [LBW-1:0]       ram_waddr;
	logic [RAM_W-1:0]     ram_wdata;
	logic                 ram_re;
	logic [RAM_W-1:0]     ram_rdata;

	logic                 old_filled;
	logic signed [SB-1:0] old_lo;
	logic signed [SB-1:0] old_hi;
	logic signed [SB-1:0] new_lo;
	logic signed [SB-1:0] new_hi;

	assign item_stall  = (state_q != ST_IDLE);
	assign item_accept = item_valid && !item_stall;
	assign cfg_ready   = 1'b1;

	// A zero bin or sample count leaves the word outside every bin.
	assign no_bin    = (tb_q == '0) || (ts_q == '0);
	assign div_start = (state_q == ST_START) && !no_bin;

	wmb_divider #(
		.DIVIDEND_W (PW),
		.DIVISOR_W  (TS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (ts_q),
		.done     (div_done),
		.quotient (quo)
	);

	// Slice test on the global bin.
	always_comb begin
		bin_ge   = (quo >= PW'(first_q));
		bin_lt   = (quo < PW'(end_q));
		bin_off  = quo - PW'(first_q);
		bin_fits = (bin_off < PW'(BIN_COUNT));
	end

	// Memory word is {filled, min, max}; a cleared word reads as unfilled.
	always_comb begin
		old_filled = ram_rdata[RAM_W-1];
		old_lo     = ram_rdata[2*SB-1:SB];
		old_hi     = ram_rdata[SB-1:0];
		new_lo     = (!old_filled || (sample_q < old_lo)) ? sample_q : old_lo;
		new_hi     = (!old_filled || (sample_q > old_hi)) ? sample_q : old_hi;
	end

	// Memory ports: clearing sweep after reset, envelope update otherwise.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = local_q;
		ram_wdata = {1'b1, new_lo, new_hi};
		ram_re    = (state_q == ST_READ);
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_UPDATE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	wmb_bin_ram #(
		.DEPTH (BIN_COUNT),
		.WIDTH (RAM_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (local_q),
		.rdata (ram_rdata)
	);

	// Configuration registers; the position counter loads on a start position
	// write and advances, saturating, per word taken with no register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tb_q    <= TRACK_BINS_RST;
			ts_q    <= TRACK_LEN_RST;
			first_q <= SLICE_FIRST_RST;
			end_q   <= SLICE_END_RST;
			pe_q    <= PUBLISH_RST;
			pos_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TRACK_BINS:     tb_q    <= cfg_data[TB_W-1:0];
				REG_TRACK_LEN:      ts_q    <= cfg_data[TS_W-1:0];
				REG_SLICE_FIRST:    first_q <= cfg_data[SF_W-1:0];
				REG_SLICE_END:      end_q   <= cfg_data[SE_W-1:0];
				REG_START_POSITION: pos_q   <= PB'(cfg_data);
				REG_PUBLISH_ENABLE: pe_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end else if (item_accept && (pos_q != '1)) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// Sequencer, working registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			hw_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// A taken result clears the valid flag unless a new one loads now.
			if (result_valid_q && !result_stall && (state_q != ST_FINISH)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LBW'(BIN_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_accept) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (no_bin) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (bin_ge && bin_lt && bin_fits) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (pe_q && (local_q > hw_q)) begin
						hw_q <= local_q;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Wait here only while the previous result is still held.
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (item_accept) begin
			sample_q <= sample;
			prod_q   <= PW'(pos_q) * PW'(tb_q);
		end
		case (state_q)
			ST_START: begin
				res_in_q <= 1'b0;
				res_lo_q <= '0;
				res_hi_q <= '0;
				local_q  <= '0;
			end
			ST_CHECK: begin
				if (bin_ge && bin_lt && bin_fits) begin
					res_in_q <= 1'b1;
					local_q  <= bin_off[LBW-1:0];
				end
			end
			ST_UPDATE: begin
				res_lo_q <= new_lo;
				res_hi_q <= new_hi;
			end
			ST_FINISH: begin
				if (!result_valid_q || !result_stall) begin
					in_slice_q  <= res_in_q;
					local_bin_q <= local_q;
					bin_low_q   <= res_lo_q;
					bin_high_q  <= res_hi_q;
					sealed_q    <= hw_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign in_slice     = in_slice_q;
	assign local_bin    = local_bin_q;
	assign bin_low      = bin_low_q;
	assign bin_high     = bin_high_q;
	assign sealed_count = sealed_q;

endmodule

>>> hdl/wmb_divider.sv
// ----------------------------------------------------------------------------
// wmb_divider: bit-serial restoring divider
// Produces one quotient bit per clock, most significant first. A start pulse
// loads the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module wmb_divider #(
	parameter int DIVIDEND_W = 53,
	parameter int DIVISOR_W  = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W+1:0]  diff;
	logic                  fits;

	// One trial subtraction: bring down the next dividend bit and test it.
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
		fits    = ~diff[DIVISOR_W+1];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register; dividend bits leave at the top
	// while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/wmb_bin_ram.sv
// ----------------------------------------------------------------------------
// wmb_bin_ram: per-bin envelope memory
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wmb_bin_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 33,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/wmb_checker.sv
// ----------------------------------------------------------------------------
// wmb_checker: port-level checks of the min/max waveform binner
// Watches the top level's ports and reports broken invariants by $error.
// ----------------------------------------------------------------------------
module wmb_checker #(
	parameter int BIN_COUNT   = 4096,
	parameter int SAMPLE_BITS = 16,
	localparam int LBW = $clog2(BIN_COUNT)
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic                          in_slice,
	input logic [LBW-1:0]                local_bin,
	input logic signed [SAMPLE_BITS-1:0] bin_low,
	input logic signed [SAMPLE_BITS-1:0] bin_high,
	input logic [LBW-1:0]                sealed_count
);

	// A stalled result word holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(in_slice) &&
		$stable(local_bin) && $stable(bin_low) && $stable(bin_high) &&
		$stable(sealed_count))
	else $error("stalled result word changed");

	// The block is busy in the cycle after it takes a sample word.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
	else $error("sample channel open right after an accepted word");

	// A word outside the slice reports zero bin and envelope.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !in_slice |-> (local_bin == '0) && (bin_low == '0) &&
		(bin_high == '0))
	else $error("out-of-slice result carries bin data");

	// A bin's minimum never exceeds its maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && in_slice |-> bin_low <= bin_high)
	else $error("bin minimum above bin maximum");

	// The sealed high-water mark never falls.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) |-> sealed_count >= $past(sealed_count))
	else $error("sealed count decreased");

endmodule

bind waveform_minmax_binner wmb_checker #(
	.BIN_COUNT   (BIN_COUNT),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_wmb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.in_slice     (in_slice),
	.local_bin    (local_bin),
	.bin_low      (bin_low),
	.bin_high     (bin_high),
	.sealed_count (sealed_count)
);

>>> tb/waveform_minmax_binner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_minmax_binner_checker: result checker for the min/max binner
// Watches the sample, result and configuration channels of the binner. It
// keeps its own copy of the settings, the track position, the per-bin
// envelope and the sealed high-water mark, works out the result word of
// every accepted sample word, and compares each accepted result word
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
module waveform_minmax_binner_checker #(
	parameter int BIN_COUNT     = 4096,
	parameter int SAMPLE_BITS   = 16,
	parameter int POSITION_BITS = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic                           in_slice,
	input  logic [$clog2(BIN_COUNT)-1:0]   local_bin,
	input  logic signed [SAMPLE_BITS-1:0]  bin_low,
	input  logic signed [SAMPLE_BITS-1:0]  bin_high,
	input  logic [$clog2(BIN_COUNT)-1:0]   sealed_count,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [wmb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wmb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             results_taken,
	output int                             slice_hits
);

	localparam int LBW         = $clog2(BIN_COUNT);
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                          in_slice;
		logic [LBW-1:0]                local_bin;
		logic signed [SAMPLE_BITS-1:0] bin_low;
		logic signed [SAMPLE_BITS-1:0] bin_high;
		logic [LBW-1:0]                sealed_count;
	} envelope_word_t;

	// Shadow copy of the settings and of the block's state.
	logic [wmb_pkg::TB_W-1:0]      set_bins;
	logic [wmb_pkg::TS_W-1:0]      set_samples;
	logic [wmb_pkg::SF_W-1:0]      set_first;
	logic [wmb_pkg::SE_W-1:0]      set_stop;
	logic                          set_publish;
	logic [POSITION_BITS-1:0]      track_pos;
	logic signed [SAMPLE_BITS-1:0] bin_min [BIN_COUNT];
	logic signed [SAMPLE_BITS-1:0] bin_max [BIN_COUNT];
	logic                          bin_filled [BIN_COUNT];
	logic [LBW-1:0]                high_mark;

	// Result words still owed by the block, oldest first.
	envelope_word_t envelope_due [$];
	int             misses;
	int             taken;
	int             hits;

	// Folds one sample into the envelope of its bin and advances the position.
	task automatic bin_envelope_step(input logic signed [SAMPLE_BITS-1:0] s,
			output envelope_word_t w);
		logic [63:0] bin;
		logic [63:0] first;
		logic [63:0] stop;
		int unsigned k;
		w = '0;
		if (set_bins != 0 && set_samples != 0) begin
			bin = 64'(track_pos);
			bin = bin * 64'(set_bins);
			bin = bin / 64'(set_samples);
			first = 64'(set_first);
			stop = 64'(set_stop);
			if (bin >= first && bin < stop && bin - first < 64'(BIN_COUNT)) begin
				k = 32'(bin - first);
				if (!bin_filled[k]) begin
					bin_min[k] = s;
					bin_max[k] = s;
					bin_filled[k] = 1'b1;
				end else begin
					if (s < bin_min[k])
						bin_min[k] = s;
					if (s > bin_max[k])
						bin_max[k] = s;
				end
				w.in_slice = 1'b1;
				w.local_bin = k[LBW-1:0];
				w.bin_low = bin_min[k];
				w.bin_high = bin_max[k];
				if (set_publish && k > 32'(high_mark))
					high_mark = k[LBW-1:0];
			end
		end
		w.sealed_count = high_mark;
		// The position sticks at its top value.
		if (track_pos != '1)
			track_pos = track_pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		envelope_word_t got;
		envelope_word_t want;
		if (!arst_n) begin
			set_bins = wmb_pkg::TRACK_BINS_RST;
			set_samples = wmb_pkg::TRACK_LEN_RST;
			set_first = wmb_pkg::SLICE_FIRST_RST;
			set_stop = wmb_pkg::SLICE_END_RST;
			set_publish = wmb_pkg::PUBLISH_RST;
			track_pos = '0;
			for (int i = 0; i < BIN_COUNT; i++)
				bin_filled[i] = 1'b0;
			high_mark = '0;
			envelope_due.delete();
			misses = 0;
			taken = 0;
			hits = 0;
		end else begin
			// Result side first: a word accepted now can only answer an older sample.
			if (result_valid && !result_stall) begin
				taken++;
				got.in_slice = in_slice;
				got.local_bin = local_bin;
				got.bin_low = bin_low;
				got.bin_high = bin_high;
				got.sealed_count = sealed_count;
				if (envelope_due.size() == 0) begin
					misses++;
					if (misses <= MAX_REPORTS)
						$display("%0t: result word with none outstanding: slice=%0b bin=%0d",
							$realtime, got.in_slice, got.local_bin);
				end else begin
					want = envelope_due.pop_front();
					if (got !== want) begin
						misses++;
						if (misses <= MAX_REPORTS) begin
							$display("%0t: result word %0d differs", $realtime, taken);
							$display("  expected slice=%0b bin=%0d low=%0d high=%0d sealed=%0d",
								want.in_slice, want.local_bin, want.bin_low,
								want.bin_high, want.sealed_count);
							$display("  actual   slice=%0b bin=%0d low=%0d high=%0d sealed=%0d",
								got.in_slice, got.local_bin, got.bin_low,
								got.bin_high, got.sealed_count);
						end
					end
				end
			end

			// Register writes; unused indexes leave everything as it was.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wmb_pkg::REG_TRACK_BINS:     set_bins = cfg_data[wmb_pkg::TB_W-1:0];
					wmb_pkg::REG_TRACK_LEN:      set_samples = cfg_data[wmb_pkg::TS_W-1:0];
					wmb_pkg::REG_SLICE_FIRST:    set_first = cfg_data[wmb_pkg::SF_W-1:0];
					wmb_pkg::REG_SLICE_END:      set_stop = cfg_data[wmb_pkg::SE_W-1:0];
					wmb_pkg::REG_START_POSITION: track_pos = cfg_data[POSITION_BITS-1:0];
					wmb_pkg::REG_PUBLISH_ENABLE: set_publish = cfg_data[0];
					default: ;
				endcase
			end

			// Every accepted sample word owes exactly one result word.
			if (item_valid && !item_stall) begin
				bin_envelope_step(sample, want);
				if (want.in_slice)
					hits++;
				envelope_due.push_back(want);
			end
		end
		fail_count <= misses;
		results_taken <= taken;
		slice_hits <= hits;
	end

endmodule

>>> tb/waveform_minmax_binner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_minmax_binner_tb: top level of the min/max binner testbench
// Drives sample words and register writes into the binner with random gaps
// and random result stalls. A short directed run covers the corner cases of
// the bin mapping; random track settings with random samples follow. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module waveform_minmax_binner_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_WORDS   = 880;
	localparam int TAIL_CYCLES    = 80;

	// Register indexes past the end of the map; writes there are dropped.
	localparam logic [wmb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [wmb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_stall;
	logic signed [15:0]             sample = '0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic                           in_slice;
	logic [11:0]                    local_bin;
	logic signed [15:0]             bin_low;
	logic signed [15:0]             bin_high;
	logic [11:0]                    sealed_count;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [wmb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wmb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int results_taken;
	int slice_hits;
	int sent = 0;
	int random_sent = 0;
	int settings = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	waveform_minmax_binner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.in_slice     (in_slice),
		.local_bin    (local_bin),
		.bin_low      (bin_low),
		.bin_high     (bin_high),
		.sealed_count (sealed_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	waveform_minmax_binner_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.in_slice      (in_slice),
		.local_bin     (local_bin),
		.bin_low       (bin_low),
		.bin_high      (bin_high),
		.sealed_count  (sealed_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.results_taken (results_taken),
		.slice_hits    (slice_hits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	// Samples lean on the rails, zero and minus one; the rest are uniform.
	function automatic logic signed [15:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return r[0] ? 16'sh0000 : 16'shFFFF;
			default: return r[15:0];
		endcase
	endfunction

	// Result side stalls at random, except during steady stretches.
	initial begin : result_side
		int unsigned n;
		forever begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
			n = idle_len();
			if (n != 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Ends the run when no channel has moved a word for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one sample word, after a random gap, and waits for it to be taken.
	task automatic send_sample(input logic signed [15:0] v);
		int unsigned g;
		g = idle_len();
		if (g != 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent++;
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [wmb_pkg::CFG_IDX_W-1:0] idx,
			input logic [wmb_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Stops offering samples and waits until every result word has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (results_taken < sent)
			@(posedge clk);
	endtask

	// Writes a full track setting. A messy setting fills the unused upper data
	// bits with noise and adds a write to an index past the register map.
	task automatic program_track(input logic [wmb_pkg::TB_W-1:0] nbins,
			input logic [wmb_pkg::TS_W-1:0] samples, input logic [wmb_pkg::SF_W-1:0] first,
			input logic [wmb_pkg::SE_W-1:0] stop, input logic [39:0] start,
			input logic publish, input logic messy);
		logic [39:0] junk;
		junk = messy ? 40'({$urandom, $urandom}) : '0;
		write_reg(wmb_pkg::REG_TRACK_BINS, {junk[39:13], nbins});
		write_reg(wmb_pkg::REG_TRACK_LEN, samples);
		write_reg(wmb_pkg::REG_SLICE_FIRST, {junk[39:12], first});
		write_reg(wmb_pkg::REG_SLICE_END, {junk[39:13], stop});
		if (messy)
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
				40'({$urandom, $urandom}));
		write_reg(wmb_pkg::REG_START_POSITION, start);
		write_reg(wmb_pkg::REG_PUBLISH_ENABLE, {junk[39:1], publish});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Picks a random track setting. Most keep many samples per bin and a
	// narrow slice, so bins fill up and the high-water mark climbs slowly;
	// late in the run, wide random settings and settings that park the
	// position at its top value join in.
	task automatic random_setting(input bit late);
		logic [wmb_pkg::TB_W-1:0] nbins;
		logic [wmb_pkg::SE_W-1:0] stop;
		logic [wmb_pkg::SF_W-1:0] first;
		logic [wmb_pkg::TS_W-1:0] samples;
		logic [39:0]              start;
		logic [63:0]              b;
		logic [63:0]              lo;
		logic [31:0]              r;
		int unsigned              kind;
		kind = $urandom_range(0, late ? 9 : 7);
		r = $urandom;
		if (kind <= 7) begin
			if (kind <= 5) begin
				nbins = 13'($urandom_range(2, 64));
				samples = 40'(nbins * $urandom_range(1, 6));
				stop = 13'($urandom_range(1, nbins));
			end else begin
				nbins = 13'($urandom_range(65, 4096));
				samples = 40'(nbins * $urandom_range(1, 3));
				stop = 13'($urandom_range(1, 40));
			end
			if (r[0])
				samples = samples + 40'($urandom_range(0, nbins - 1));
			first = 12'($urandom_range(0, nbins - 1));
			stop = stop + 13'(first);
			// Start either just ahead of the slice or anywhere in the track.
			if (r[1]) begin
				b = 64'(first);
				b = b * 64'(samples) / 64'(nbins);
				start = (b > 3) ? 40'(b - 64'($urandom_range(0, 3))) : '0;
			end else begin
				start = 40'($urandom_range(0, 32'(samples - 40'd1)));
			end
		end else if (kind == 8) begin
			nbins = r[12:0];
			samples = (r[15:13] == 3'd0) ? '0 : 40'({$urandom, $urandom});
			start = 40'({$urandom, $urandom});
			first = r[27:16];
			stop = 13'($urandom);
		end else begin
			nbins = 13'($urandom_range(1, 4096));
			samples = 40'({$urandom, $urandom}) | {1'b1, 39'd0};
			start = '1 - 40'($urandom_range(0, 30));
			b = {24'd0, {40{1'b1}}};
			b = b * 64'(nbins) / 64'(samples);
			lo = (b > 20) ? b - 64'($urandom_range(0, 20)) : '0;
			first = (lo > 4095) ? 12'd4095 : lo[11:0];
			stop = (b >= 8191) ? 13'd8191 : b[12:0] + 1'b1;
		end
		program_track(nbins, samples, first, stop, start, $urandom_range(0, 4) != 0,
			1'($urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: only position zero lands in a bin, later ones run past the end.
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0001);
		drain();

		// Eight bins over ten samples, slice of bins two to five: first fills,
		// min and max updates, and a rising high-water mark.
		program_track(13'd8, 40'd10, 12'd2, 13'd6, 40'd3, 1'b1, 1'b1);
		send_sample(16'sh0000);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'shFFFF);
		send_sample(16'sh1234);
		drain();

		// No bins, then no samples: nothing can be in the slice.
		program_track(13'd0, 40'd16, 12'd0, 13'd16, 40'd0, 1'b1, 1'b0);
		send_sample(16'sh4000);
		send_sample(16'shC000);
		drain();
		program_track(13'd16, 40'd0, 12'd0, 13'd16, 40'd0, 1'b1, 1'b0);
		send_sample(16'sh5555);
		drain();

		// Inverted slice, then an empty one.
		program_track(13'd8, 40'd16, 12'd5, 13'd3, 40'd10, 1'b1, 1'b0);
		send_sample(16'shAAAA);
		drain();
		program_track(13'd8, 40'd16, 12'd4, 13'd4, 40'd8, 1'b1, 1'b0);
		send_sample(16'sh0F0F);
		drain();

		// Slice wider than the bin store: local bins past the store are out.
		program_track(13'd8191, 40'd8191, 12'd0, 13'd8191, 40'd5000, 1'b1, 1'b0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		drain();

		// Publishing off: in-slice bins above the mark leave it where it is.
		program_track(13'd16, 40'd16, 12'd0, 13'd16, 40'd10, 1'b0, 1'b0);
		send_sample(16'sh0100);
		send_sample(16'shFF00);
		drain();

		// Position at the top of its range: it sticks and keeps its bin.
		program_track(13'd4095, 40'hFF_FFFF_FFFF, 12'd4090, 13'd4096,
			40'hFF_FFFF_FFFE, 1'b1, 1'b0);
		send_sample(16'sh0001);
		send_sample(16'shFFFE);
		send_sample(16'sh8000);
		drain();

		// Random settings, each followed by a batch of random sample words.
		while (random_sent < RANDOM_WORDS) begin
			random_setting(random_sent > RANDOM_WORDS * 2 / 3);
			steady = ($urandom_range(0, 4) == 0);
			n = $urandom_range(20, 60);
			repeat (n) begin
				send_sample(pick_sample());
				random_sent++;
			end
			drain();
			steady = 1'b0;
		end

		// Give a stray extra result word time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d sample words over %0d track settings, %0d of them inside a slice",
			sent, settings, slice_hits);
		$display("%0d result words compared, %0d mismatches", results_taken, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
